// ===== rtl/core/ackc_pkg.sv =====
package ackc_pkg;

	// item kinds
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_KEY  = 1'b1;

	// key numbers
	localparam logic [3:0] KEY_SEL_HOUR = 4'd1;
	localparam logic [3:0] KEY_SEL_MIN  = 4'd2;
	localparam logic [3:0] KEY_SEL_SEC  = 4'd3;
	localparam logic [3:0] KEY_INC      = 4'd4;
	localparam logic [3:0] KEY_DEC      = 4'd5;
	localparam logic [3:0] KEY_RUN      = 4'd6;
	localparam logic [3:0] KEY_EDIT_CLK = 4'd7;
	localparam logic [3:0] KEY_EDIT_ALM = 4'd8;
	localparam logic [3:0] KEY_SILENCE  = 4'd9;

	// edit modes
	localparam logic [1:0] MODE_RUN = 2'd0;
	localparam logic [1:0] MODE_CLK = 2'd1;
	localparam logic [1:0] MODE_ALM = 2'd2;

	// field selection
	localparam logic [1:0] SEL_NONE = 2'd0;
	localparam logic [1:0] SEL_HOUR = 2'd1;
	localparam logic [1:0] SEL_MIN  = 2'd2;
	localparam logic [1:0] SEL_SEC  = 2'd3;

	localparam logic [5:0] HOUR_TOP = 6'd23;
	localparam logic [5:0] MS_TOP   = 6'd59;

	localparam logic [4:0] CLK_HOUR_RST = 5'd23;
	localparam logic [5:0] CLK_MIN_RST  = 6'd59;
	localparam logic [5:0] CLK_SEC_RST  = 6'd50;
	localparam logic [4:0] ALM_HOUR_RST = 5'd23;
	localparam logic [5:0] ALM_MIN_RST  = 6'd0;
	localparam logic [5:0] ALM_SEC_RST  = 6'd0;

	typedef struct packed {
		logic [2:0] tens;
		logic [3:0] ones;
	} dec_t;

	// values stay below 60, so a compare chain gives the tens digit
	function automatic dec_t split_dec(input logic [5:0] v);
		dec_t d;
		if (v >= 6'd50) begin
			d.tens = 3'd5;
			d.ones = 4'(v - 6'd50);
		end else if (v >= 6'd40) begin
			d.tens = 3'd4;
			d.ones = 4'(v - 6'd40);
		end else if (v >= 6'd30) begin
			d.tens = 3'd3;
			d.ones = 4'(v - 6'd30);
		end else if (v >= 6'd20) begin
			d.tens = 3'd2;
			d.ones = 4'(v - 6'd20);
		end else if (v >= 6'd10) begin
			d.tens = 3'd1;
			d.ones = 4'(v - 6'd10);
		end else begin
			d.tens = 3'd0;
			d.ones = v[3:0];
		end
		return d;
	endfunction

	function automatic logic [5:0] wrap_up(input logic [5:0] v, input logic [5:0] top);
		return (v >= top) ? 6'd0 : 6'(v + 6'd1);
	endfunction

	function automatic logic [5:0] wrap_down(input logic [5:0] v, input logic [5:0] top);
		return (v == 6'd0 || v > top) ? top : 6'(v - 6'd1);
	endfunction

endpackage

// ===== rtl/core/alarm_clock_keypad_control_core.sv =====
// channel | signals                               | direction | accepted when
// input   | in_valid, in_ready, opcode, key_code  | in        | in_valid && in_ready
// output  | out_valid, out_ready, hour_tens ..    | out       | out_valid && out_ready
//           second_ones, buzzer_on, edit_mode
//
// one item per cycle sustained while out_ready holds; an item's result becomes valid once it moves
// from the input register, through state update and digit split, into the result register
// the input register keeps accepting while a result waits, until both stages are full
// reset: clock 23:59:50, alarm 23:00:00, running, nothing selected, silent
module alarm_clock_keypad_control_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       opcode,
	input  logic [3:0] key_code,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] hour_tens,
	output logic [3:0] hour_ones,
	output logic [2:0] minute_tens,
	output logic [3:0] minute_ones,
	output logic [2:0] second_tens,
	output logic [3:0] second_ones,
	output logic       buzzer_on,
	output logic [1:0] edit_mode
);
	import ackc_pkg::*;

	logic       valid_s1;
	logic       op_s1;
	logic [3:0] key_s1;
	logic       upd;

	logic [4:0] clk_hour_q;
	logic [5:0] clk_min_q, clk_sec_q;
	logic [4:0] alm_hour_q;
	logic [5:0] alm_min_q, alm_sec_q;
	logic [1:0] mode_q, clk_sel_q, alm_sel_q;
	logic       ring_q;
	logic       out_valid_q;

	logic [4:0] clk_hour_d, alm_hour_d;
	logic [5:0] clk_min_d, clk_sec_d, alm_min_d, alm_sec_d;
	logic [1:0] mode_d, clk_sel_d, alm_sel_d;
	logic       ring_d;
	logic       adv;
	logic       edit_key;
	logic [5:0] show_h, show_m, show_s;
	dec_t       dh, dm, ds;

	logic [1:0] hour_tens_q;
	logic [3:0] hour_ones_q, minute_ones_q, second_ones_q;
	logic [2:0] minute_tens_q, second_tens_q;
	logic       buzzer_q;
	logic [1:0] edit_mode_q;

	assign upd      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || upd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1  <= opcode;
			key_s1 <= key_code;
		end
	end

	always_comb begin
		clk_hour_d = clk_hour_q;
		clk_min_d  = clk_min_q;
		clk_sec_d  = clk_sec_q;
		alm_hour_d = alm_hour_q;
		alm_min_d  = alm_min_q;
		alm_sec_d  = alm_sec_q;
		mode_d     = mode_q;
		clk_sel_d  = clk_sel_q;
		alm_sel_d  = alm_sel_q;
		ring_d     = ring_q;
		adv        = 1'b0;
		edit_key   = (key_s1 == KEY_INC) || (key_s1 == KEY_DEC);

		if (op_s1 == OP_TICK) begin
			if (ring_q) begin
				adv = 1'b1;
			end else if (mode_q == MODE_RUN) begin
				adv = 1'b1;
				if (clk_hour_q == alm_hour_q && clk_min_q == alm_min_q &&
				    clk_sec_q == alm_sec_q) begin
					ring_d = 1'b1;
				end
			end
		end else begin
			case (key_s1)
				KEY_SEL_HOUR, KEY_SEL_MIN, KEY_SEL_SEC: begin
					if (mode_q == MODE_CLK) clk_sel_d = key_s1[1:0];
					else if (mode_q == MODE_ALM) alm_sel_d = key_s1[1:0];
				end
				KEY_RUN:      mode_d = MODE_RUN;
				KEY_EDIT_CLK: mode_d = MODE_CLK;
				KEY_EDIT_ALM: mode_d = MODE_ALM;
				KEY_SILENCE:  ring_d = 1'b0;
				default: ;
			endcase

			if (edit_key && mode_q == MODE_CLK) begin
				case (clk_sel_q)
					SEL_HOUR: clk_hour_d = 5'((key_s1 == KEY_INC) ?
						wrap_up({1'b0, clk_hour_q}, HOUR_TOP) :
						wrap_down({1'b0, clk_hour_q}, HOUR_TOP));
					SEL_MIN: clk_min_d = (key_s1 == KEY_INC) ?
						wrap_up(clk_min_q, MS_TOP) : wrap_down(clk_min_q, MS_TOP);
					SEL_SEC: clk_sec_d = (key_s1 == KEY_INC) ?
						wrap_up(clk_sec_q, MS_TOP) : wrap_down(clk_sec_q, MS_TOP);
					default: ;
				endcase
			end
			if (edit_key && mode_q == MODE_ALM) begin
				case (alm_sel_q)
					SEL_HOUR: alm_hour_d = 5'((key_s1 == KEY_INC) ?
						wrap_up({1'b0, alm_hour_q}, HOUR_TOP) :
						wrap_down({1'b0, alm_hour_q}, HOUR_TOP));
					SEL_MIN: alm_min_d = (key_s1 == KEY_INC) ?
						wrap_up(alm_min_q, MS_TOP) : wrap_down(alm_min_q, MS_TOP);
					SEL_SEC: alm_sec_d = (key_s1 == KEY_INC) ?
						wrap_up(alm_sec_q, MS_TOP) : wrap_down(alm_sec_q, MS_TOP);
					default: ;
				endcase
			end
		end

		// seconds carry into minutes, minutes into hours
		if (adv) begin
			if (clk_sec_q >= MS_TOP) begin
				clk_sec_d = 6'd0;
				if (clk_min_q >= MS_TOP) begin
					clk_min_d  = 6'd0;
					clk_hour_d = (clk_hour_q >= HOUR_TOP[4:0]) ? 5'd0 : 5'(clk_hour_q + 5'd1);
				end else begin
					clk_min_d = 6'(clk_min_q + 6'd1);
				end
			end else begin
				clk_sec_d = 6'(clk_sec_q + 6'd1);
			end
		end

		if (mode_d == MODE_ALM) begin
			show_h = {1'b0, alm_hour_d};
			show_m = alm_min_d;
			show_s = alm_sec_d;
		end else begin
			show_h = {1'b0, clk_hour_d};
			show_m = clk_min_d;
			show_s = clk_sec_d;
		end
		dh = split_dec(show_h);
		dm = split_dec(show_m);
		ds = split_dec(show_s);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hour_q  <= CLK_HOUR_RST;
			clk_min_q   <= CLK_MIN_RST;
			clk_sec_q   <= CLK_SEC_RST;
			alm_hour_q  <= ALM_HOUR_RST;
			alm_min_q   <= ALM_MIN_RST;
			alm_sec_q   <= ALM_SEC_RST;
			mode_q      <= MODE_RUN;
			clk_sel_q   <= SEL_NONE;
			alm_sel_q   <= SEL_NONE;
			ring_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (upd) begin
				clk_hour_q <= clk_hour_d;
				clk_min_q  <= clk_min_d;
				clk_sec_q  <= clk_sec_d;
				alm_hour_q <= alm_hour_d;
				alm_min_q  <= alm_min_d;
				alm_sec_q  <= alm_sec_d;
				mode_q     <= mode_d;
				clk_sel_q  <= clk_sel_d;
				alm_sel_q  <= alm_sel_d;
				ring_q     <= ring_d;
			end
			if (upd) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			hour_tens_q   <= dh.tens[1:0];
			hour_ones_q   <= dh.ones;
			minute_tens_q <= dm.tens;
			minute_ones_q <= dm.ones;
			second_tens_q <= ds.tens;
			second_ones_q <= ds.ones;
			buzzer_q      <= ring_d;
			edit_mode_q   <= mode_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign hour_tens   = hour_tens_q;
	assign hour_ones   = hour_ones_q;
	assign minute_tens = minute_tens_q;
	assign minute_ones = minute_ones_q;
	assign second_tens = second_tens_q;
	assign second_ones = second_ones_q;
	assign buzzer_on   = buzzer_q;
	assign edit_mode   = edit_mode_q;

	// ringing only starts on a tick
	a_ring_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ring_q) |-> $past(upd && op_s1 == OP_TICK))
		else $error("ringing started without a tick");

	// time values stay in range
	a_clk_range: assert property (@(posedge clk) disable iff (!arst_n)
		clk_hour_q <= HOUR_TOP[4:0] && clk_min_q <= MS_TOP && clk_sec_q <= MS_TOP &&
		alm_hour_q <= HOUR_TOP[4:0] && alm_min_q <= MS_TOP && alm_sec_q <= MS_TOP)
		else $error("time field out of range");

	// state moves only with an item
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!upd |=> $stable(clk_sec_q) && $stable(mode_q) && $stable(ring_q))
		else $error("state changed without an item");

	// a waiting result matches the current mode and ringing flag
	a_out_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (edit_mode_q == mode_q && buzzer_q == ring_q))
		else $error("result disagrees with state");

endmodule

// ===== sim/alarm_clock_keypad_control_core_test.sv =====
`timescale 1ns / 1ps

module alarm_clock_keypad_control_core_test;
	import ackc_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 12;
	localparam int RANDOM_ITEMS = 400;
	localparam int CALM_TAIL = 50;
	localparam int PRESSURE_AT = 150;
	localparam int LONG_HOLD = 200;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int REPORT_MAX = 10;

	// keys that do nothing
	localparam logic [3:0] KEY_IDLE_LO = 4'd0;
	localparam logic [3:0] KEY_IDLE_HI = 4'd15;

	typedef struct packed {
		logic [1:0] hour_tens;
		logic [3:0] hour_ones;
		logic [2:0] minute_tens;
		logic [3:0] minute_ones;
		logic [2:0] second_tens;
		logic [3:0] second_ones;
		logic       buzzer_on;
		logic [1:0] edit_mode;
	} display_t;

	typedef struct packed {
		logic       op;
		logic [3:0] key;
		logic       pinned;
		display_t   want;
	} script_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       opcode = OP_TICK;
	logic [3:0] key_code = KEY_IDLE_LO;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] hour_tens;
	logic [3:0] hour_ones;
	logic [2:0] minute_tens;
	logic [3:0] minute_ones;
	logic [2:0] second_tens;
	logic [3:0] second_ones;
	logic       buzzer_on;
	logic [1:0] edit_mode;

	alarm_clock_keypad_control_core dut (.*);

	// shadow copy of the clock state
	logic [4:0] now_hr = CLK_HOUR_RST;
	logic [5:0] now_min = CLK_MIN_RST;
	logic [5:0] now_sec = CLK_SEC_RST;
	logic [4:0] alm_hr = ALM_HOUR_RST;
	logic [5:0] alm_min = ALM_MIN_RST;
	logic [5:0] alm_sec = ALM_SEC_RST;
	logic [1:0] cur_mode = MODE_RUN;
	logic [1:0] now_pick = SEL_NONE;
	logic [1:0] alm_pick = SEL_NONE;
	logic       ringing = 1'b0;

	display_t due_displays[$];
	int mistakes = 0;
	int sent = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	always #HALF_PERIOD clk = ~clk;

	function automatic display_t show(input logic [5:0] h, input logic [5:0] m,
			input logic [5:0] s, input logic buzz, input logic [1:0] md);
		display_t d;
		d.hour_tens = 2'(h / 6'd10);
		d.hour_ones = 4'(h % 6'd10);
		d.minute_tens = 3'(m / 6'd10);
		d.minute_ones = 4'(m % 6'd10);
		d.second_tens = 3'(s / 6'd10);
		d.second_ones = 4'(s % 6'd10);
		d.buzzer_on = buzz;
		d.edit_mode = md;
		return d;
	endfunction

	function automatic string as_text(input display_t d);
		return $sformatf("%0d%0d:%0d%0d:%0d%0d buzzer %0d mode %0d", d.hour_tens, d.hour_ones,
			d.minute_tens, d.minute_ones, d.second_tens, d.second_ones, d.buzzer_on,
			d.edit_mode);
	endfunction

	function automatic script_row_t plain_row(input logic op, input logic [3:0] key);
		script_row_t r;
		r.op = op;
		r.key = key;
		r.pinned = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic script_row_t known_row(input logic op, input logic [3:0] key,
			input display_t want);
		script_row_t r;
		r.op = op;
		r.key = key;
		r.pinned = 1'b1;
		r.want = want;
		return r;
	endfunction

	// inc/dec of one field with wraparound, only when that field is selected
	function automatic logic [5:0] bump(input logic hit, input logic [3:0] key,
			input logic [5:0] v, input logic [5:0] top);
		if (!hit)
			return v;
		if (key == KEY_INC)
			return (v >= top) ? 6'd0 : v + 6'd1;
		if (key == KEY_DEC)
			return (v == 6'd0 || v > top) ? top : v - 6'd1;
		return v;
	endfunction

	task automatic run_second();
		if (now_sec >= MS_TOP) begin
			now_sec = '0;
			if (now_min >= MS_TOP) begin
				now_min = '0;
				now_hr = (now_hr >= 5'(HOUR_TOP)) ? 5'd0 : now_hr + 5'd1;
			end else begin
				now_min = now_min + 6'd1;
			end
		end else begin
			now_sec = now_sec + 6'd1;
		end
	endtask

	task automatic advance_clock_state(input logic op, input logic [3:0] key,
			output display_t shown);
		if (op == OP_TICK) begin
			if (ringing) begin
				run_second();
			end else if (cur_mode == MODE_RUN) begin
				// the matching tick rings and still advances
				if (now_hr == alm_hr && now_min == alm_min && now_sec == alm_sec)
					ringing = 1'b1;
				run_second();
			end
		end else begin
			if (key == KEY_EDIT_CLK)
				cur_mode = MODE_CLK;
			if (cur_mode == MODE_CLK) begin
				if (key >= KEY_SEL_HOUR && key <= KEY_SEL_SEC)
					now_pick = key[1:0];
				now_hr = 5'(bump(now_pick == SEL_HOUR, key, {1'b0, now_hr}, HOUR_TOP));
				now_min = bump(now_pick == SEL_MIN, key, now_min, MS_TOP);
				now_sec = bump(now_pick == SEL_SEC, key, now_sec, MS_TOP);
			end
			if (key == KEY_EDIT_ALM)
				cur_mode = MODE_ALM;
			if (cur_mode == MODE_ALM && key != KEY_EDIT_ALM) begin
				if (key >= KEY_SEL_HOUR && key <= KEY_SEL_SEC)
					alm_pick = key[1:0];
				alm_hr = 5'(bump(alm_pick == SEL_HOUR, key, {1'b0, alm_hr}, HOUR_TOP));
				alm_min = bump(alm_pick == SEL_MIN, key, alm_min, MS_TOP);
				alm_sec = bump(alm_pick == SEL_SEC, key, alm_sec, MS_TOP);
			end
			if (key == KEY_RUN)
				cur_mode = MODE_RUN;
			if (key == KEY_SILENCE)
				ringing = 1'b0;
		end
		if (cur_mode == MODE_ALM)
			shown = show({1'b0, alm_hr}, alm_min, alm_sec, ringing, cur_mode);
		else
			shown = show({1'b0, now_hr}, now_min, now_sec, ringing, cur_mode);
	endtask

	// offer one item, wait for it to be taken, then predict its display
	task automatic send(input logic op, input logic [3:0] key, input bit pinned = 1'b0,
			input display_t want = '0);
		display_t shown;
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		key_code <= key;
		do @(posedge clk); while (!in_ready);
		advance_clock_state(op, key, shown);
		due_displays.push_back(pinned ? want : shown);
		sent++;
	endtask

	// select a field of the target being edited and step it to a value, shortest way round
	task automatic align(input logic [3:0] sel_key, input int cur, input int target,
			input int span);
		int up;
		up = (target - cur + span) % span;
		send(OP_KEY, sel_key);
		if (up <= span / 2)
			repeat (up) send(OP_KEY, KEY_INC);
		else
			repeat (span - up) send(OP_KEY, KEY_DEC);
	endtask

	task automatic report(input string what, input display_t want, input display_t got);
		mistakes++;
		if (mistakes <= REPORT_MAX)
			$display("%0t: %s: expected %s, got %s", $time, what, as_text(want),
				as_text(got));
	endtask

	always @(posedge clk) begin : monitor
		display_t got;
		display_t want;
		string bad;
		if (arst_n && out_valid && out_ready) begin
			got = {hour_tens, hour_ones, minute_tens, minute_ones, second_tens, second_ones,
				buzzer_on, edit_mode};
			if (due_displays.size() == 0) begin
				report("result with no item pending", '0, got);
			end else begin
				want = due_displays.pop_front();
				bad = "";
				if (got.hour_tens !== want.hour_tens) bad = {bad, " hour_tens"};
				if (got.hour_ones !== want.hour_ones) bad = {bad, " hour_ones"};
				if (got.minute_tens !== want.minute_tens) bad = {bad, " minute_tens"};
				if (got.minute_ones !== want.minute_ones) bad = {bad, " minute_ones"};
				if (got.second_tens !== want.second_tens) bad = {bad, " second_tens"};
				if (got.second_ones !== want.second_ones) bad = {bad, " second_ones"};
				if (got.buzzer_on !== want.buzzer_on) bad = {bad, " buzzer_on"};
				if (got.edit_mode !== want.edit_mode) bad = {bad, " edit_mode"};
				if (bad != "")
					report({"wrong", bad}, want, got);
			end
		end
	end

	initial begin : receiver
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				// long hold so both stages fill and the input stalls
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				out_ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		script_row_t script[$];
		int pick;
		int steps;
		bit pressed;
		pressed = 1'b0;

		script.push_back(known_row(OP_TICK, KEY_IDLE_LO,
			show(6'd23, 6'd59, 6'd51, 1'b0, MODE_RUN)));
		script.push_back(plain_row(OP_KEY, KEY_IDLE_HI));
		script.push_back(plain_row(OP_KEY, KEY_INC));
		script.push_back(plain_row(OP_KEY, KEY_SILENCE));
		script.push_back(known_row(OP_KEY, KEY_EDIT_ALM,
			show(6'd23, 6'd0, 6'd0, 1'b0, MODE_ALM)));
		script.push_back(plain_row(OP_KEY, KEY_DEC));
		script.push_back(plain_row(OP_KEY, KEY_SEL_MIN));
		script.push_back(known_row(OP_KEY, KEY_DEC,
			show(6'd23, 6'd59, 6'd0, 1'b0, MODE_ALM)));
		script.push_back(plain_row(OP_KEY, KEY_SEL_SEC));
		script.push_back(known_row(OP_KEY, KEY_DEC,
			show(6'd23, 6'd59, 6'd59, 1'b0, MODE_ALM)));
		script.push_back(plain_row(OP_KEY, KEY_EDIT_CLK));
		script.push_back(plain_row(OP_TICK, KEY_IDLE_HI));
		script.push_back(plain_row(OP_KEY, KEY_INC));
		script.push_back(plain_row(OP_KEY, KEY_SEL_HOUR));
		script.push_back(known_row(OP_KEY, KEY_INC,
			show(6'd0, 6'd59, 6'd51, 1'b0, MODE_CLK)));
		script.push_back(known_row(OP_KEY, KEY_DEC,
			show(6'd23, 6'd59, 6'd51, 1'b0, MODE_CLK)));
		script.push_back(plain_row(OP_KEY, KEY_RUN));
		for (int i = 0; i < 8; i++)
			script.push_back(plain_row(OP_TICK, i[0] ? KEY_IDLE_HI : KEY_IDLE_LO));
		// clock meets the alarm at 23:59:59 and rolls over to midnight
		script.push_back(known_row(OP_TICK, KEY_IDLE_LO,
			show(6'd0, 6'd0, 6'd0, 1'b1, MODE_RUN)));
		script.push_back(plain_row(OP_KEY, KEY_EDIT_ALM));
		script.push_back(plain_row(OP_TICK, KEY_IDLE_LO));
		script.push_back(known_row(OP_KEY, KEY_SILENCE,
			show(6'd23, 6'd59, 6'd59, 1'b0, MODE_ALM)));

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			send(script[i].op, script[i].key, script[i].pinned, script[i].want);

		while (sent < script.size() + RANDOM_ITEMS) begin
			if (sent >= script.size() + RANDOM_ITEMS - CALM_TAIL)
				calm = 1'b1;
			if (!pressed && sent >= script.size() + PRESSURE_AT) begin
				hold_req = 1'b1;
				pressed = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				// set the alarm to the current clock time, run, let it ring
				send(OP_KEY, KEY_SILENCE);
				send(OP_KEY, KEY_EDIT_ALM);
				align(KEY_SEL_HOUR, int'(alm_hr), int'(now_hr), 24);
				align(KEY_SEL_MIN, int'(alm_min), int'(now_min), 60);
				align(KEY_SEL_SEC, int'(alm_sec), int'(now_sec), 60);
				send(OP_KEY, KEY_RUN);
				repeat ($urandom_range(1, 4)) send(OP_TICK, 4'($urandom));
				// edits and ticks while ringing
				repeat ($urandom_range(0, 8)) begin
					if ($urandom_range(0, 2) == 0)
						send(OP_TICK, 4'($urandom));
					else
						send(OP_KEY, 4'($urandom_range(KEY_SEL_HOUR, KEY_EDIT_ALM)));
				end
				send(OP_KEY, KEY_SILENCE);
			end else if (pick < 55) begin
				send(OP_KEY, $urandom_range(0, 1) ? KEY_EDIT_CLK : KEY_EDIT_ALM);
				repeat ($urandom_range(1, 10)) begin
					pick = $urandom_range(0, 9);
					if (pick < 3) begin
						send(OP_KEY, 4'($urandom_range(KEY_SEL_HOUR, KEY_SEL_SEC)));
					end else if (pick < 7) begin
						send(OP_KEY, pick[0] ? KEY_INC : KEY_DEC);
					end else if (pick == 7) begin
						// long run of inc or dec steps, which may pass the wrap point
						steps = $urandom_range(5, 30);
						pick = $urandom_range(0, 1);
						repeat (steps) send(OP_KEY, pick[0] ? KEY_INC : KEY_DEC);
					end else if (pick == 8) begin
						send(OP_KEY, $urandom_range(0, 1) ? KEY_EDIT_CLK : KEY_EDIT_ALM);
					end else begin
						send(OP_TICK, 4'($urandom));
					end
				end
				if ($urandom_range(0, 1))
					send(OP_KEY, KEY_RUN);
			end else if (pick < 80) begin
				if ($urandom_range(0, 1))
					send(OP_KEY, KEY_RUN);
				repeat ($urandom_range(1, 8)) send(OP_TICK, 4'($urandom));
			end else begin
				repeat ($urandom_range(1, 4)) send(1'($urandom), 4'($urandom));
			end
		end
		in_valid <= 1'b0;

		while (due_displays.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mistakes == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
